// File: sv/msx_pkg.sv
package msx_pkg;

   // data memory depth in 32-bit words (power of two; word index is a bit slice)
   localparam int unsigned DATA_WORDS = 1024;
   localparam int unsigned DMEM_AW = $clog2(DATA_WORDS);

   localparam logic [5:0] OP_RFORMAT  = 6'd0;
   localparam logic [5:0] OP_J        = 6'd2;
   localparam logic [5:0] OP_JAL      = 6'd3;
   localparam logic [5:0] OP_BEQ      = 6'd4;
   localparam logic [5:0] OP_BNE      = 6'd5;
   localparam logic [5:0] OP_BLEZ     = 6'd6;
   localparam logic [5:0] OP_ADDI     = 6'd8;
   localparam logic [5:0] OP_ADDI_UNS = 6'd9;
   localparam logic [5:0] OP_SLTI     = 6'd10;
   localparam logic [5:0] OP_SLTI_UNS = 6'd11;
   localparam logic [5:0] OP_ORI      = 6'd13;
   localparam logic [5:0] OP_LUI      = 6'd15;
   localparam logic [5:0] OP_LB       = 6'd32;
   localparam logic [5:0] OP_LW       = 6'd35;
   localparam logic [5:0] OP_LBU      = 6'd36;
   localparam logic [5:0] OP_SB       = 6'd40;
   localparam logic [5:0] OP_SW       = 6'd43;

   localparam logic [5:0] FN_SLL  = 6'd0;
   localparam logic [5:0] FN_SRL  = 6'd2;
   localparam logic [5:0] FN_SRA  = 6'd3;
   localparam logic [5:0] FN_JR   = 6'd8;
   localparam logic [5:0] FN_JALR = 6'd9;
   localparam logic [5:0] FN_ADD  = 6'd32;
   localparam logic [5:0] FN_ADDU = 6'd33;
   localparam logic [5:0] FN_SUB  = 6'd34;
   localparam logic [5:0] FN_SUBU = 6'd35;
   localparam logic [5:0] FN_AND  = 6'd36;
   localparam logic [5:0] FN_OR   = 6'd37;
   localparam logic [5:0] FN_XOR  = 6'd38;
   localparam logic [5:0] FN_NOR  = 6'd39;
   localparam logic [5:0] FN_SLT  = 6'd42;

   localparam logic [31:0] JUMP_REGION_MASK = 32'hF000_0000;
   localparam logic [4:0]  LINK_REG         = 5'd31;
   localparam logic [31:0] INSN_BYTES       = 32'd4;

   typedef struct packed {
      logic        we;
      logic [4:0]  idx;
      logic [31:0] data;
   } rf_write_type;

   typedef struct packed {
      logic [31:0] next_fetch;
      logic        reg_we;
      logic [4:0]  reg_idx;
      logic [31:0] reg_val;
      logic        store;
      logic [31:0] data_addr;
      logic [31:0] store_val;
      logic        taken;
      logic        bad;
      logic        jump;
      logic [31:0] target;
      logic        load;
      logic        load_byte;
      logic        load_signed;
      logic [1:0]  byte_lane;
      logic [3:0]  mem_be;
      logic [31:0] mem_wdata;
   } exec_result_type;

endpackage

// File: sv/msx_regfile.sv
module msx_regfile
   import msx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         read_enable,
   input  logic [4:0]   read_index_a,
   input  logic [4:0]   read_index_b,
   input  rf_write_type write_port,
   output logic [31:0]  read_data_a,
   output logic [31:0]  read_data_b
);

   logic [31:0] rf_mem_ff [32];
   logic [31:0] valid_ff;
   logic [31:0] data_a_ff;
   logic [31:0] data_b_ff;

   // entries never written read as zero; register 0 is never written
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (write_port.we) begin
         valid_ff[write_port.idx] <= 1'b1;
      end
   end

   // write-first: a read at the edge of a write to the same entry sees the new value
   always_ff @(posedge clock) begin
      if (write_port.we) begin
         rf_mem_ff[write_port.idx] <= write_port.data;
      end
      if (read_enable) begin
         if (write_port.we && write_port.idx == read_index_a) begin
            data_a_ff <= write_port.data;
         end else if (valid_ff[read_index_a]) begin
            data_a_ff <= rf_mem_ff[read_index_a];
         end else begin
            data_a_ff <= '0;
         end
         if (write_port.we && write_port.idx == read_index_b) begin
            data_b_ff <= write_port.data;
         end else if (valid_ff[read_index_b]) begin
            data_b_ff <= rf_mem_ff[read_index_b];
         end else begin
            data_b_ff <= '0;
         end
      end
   end

   assign read_data_a = data_a_ff;
   assign read_data_b = data_b_ff;

endmodule

// File: sv/msx_exec.sv
module msx_exec
   import msx_pkg::*;
(
   input  logic [31:0]     instruction,
   input  logic [31:0]     operand_a,
   input  logic [31:0]     operand_b,
   input  logic [31:0]     pc,
   input  logic            redirect_pending,
   input  logic [31:0]     redirect_target,
   output exec_result_type result
);

   logic [5:0]  op;
   logic [5:0]  fn;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [4:0]  sa;
   logic [31:0] imm_zx;
   logic [31:0] imm_sx;
   logic [31:0] npc;
   logic [31:0] link;
   logic [31:0] addr;

   assign op     = instruction[31:26];
   assign rt     = instruction[20:16];
   assign rd     = instruction[15:11];
   assign sa     = instruction[10:6];
   assign fn     = instruction[5:0];
   assign imm_zx = {16'h0000, instruction[15:0]};
   assign imm_sx = {{16{instruction[15]}}, instruction[15:0]};
   assign npc    = redirect_pending ? redirect_target : pc + INSN_BYTES;
   assign link   = npc + INSN_BYTES;
   assign addr   = operand_a + imm_sx;

   always_comb begin
      exec_result_type r;
      r = '0;
      r.next_fetch = npc;
      unique case (op)
         OP_RFORMAT: begin
            r.reg_idx = rd;
            unique case (fn)
               FN_ADD, FN_ADDU: begin r.reg_we = 1'b1; r.reg_val = operand_a + operand_b; end
               FN_SUB, FN_SUBU: begin r.reg_we = 1'b1; r.reg_val = operand_a - operand_b; end
               FN_AND: begin r.reg_we = 1'b1; r.reg_val = operand_a & operand_b; end
               FN_OR:  begin r.reg_we = 1'b1; r.reg_val = operand_a | operand_b; end
               FN_XOR: begin r.reg_we = 1'b1; r.reg_val = operand_a ^ operand_b; end
               FN_NOR: begin r.reg_we = 1'b1; r.reg_val = ~(operand_a | operand_b); end
               FN_SLT: begin
                  r.reg_we  = 1'b1;
                  r.reg_val = {31'd0, $signed(operand_a) < $signed(operand_b)};
               end
               FN_SLL: begin r.reg_we = 1'b1; r.reg_val = operand_b << sa; end
               FN_SRL: begin r.reg_we = 1'b1; r.reg_val = operand_b >> sa; end
               FN_SRA: begin
                  r.reg_we  = 1'b1;
                  r.reg_val = 32'($signed(operand_b) >>> sa);
               end
               FN_JR: begin r.jump = 1'b1; r.target = operand_a; end
               FN_JALR: begin
                  r.jump    = 1'b1;
                  r.target  = operand_a;
                  r.reg_we  = 1'b1;
                  r.reg_val = link;
               end
               default: r.bad = 1'b1;
            endcase
         end
         OP_J, OP_JAL: begin
            r.jump   = 1'b1;
            r.target = (npc & JUMP_REGION_MASK) | {4'h0, instruction[25:0], 2'b00};
            if (op == OP_JAL) begin
               r.reg_we  = 1'b1;
               r.reg_idx = LINK_REG;
               r.reg_val = link;
            end
         end
         OP_BEQ, OP_BNE, OP_BLEZ: begin
            if (op == OP_BEQ) begin
               r.taken = (operand_a == operand_b);
            end else if (op == OP_BNE) begin
               r.taken = (operand_a != operand_b);
            end else begin
               r.taken = (operand_a == 32'd0) || operand_a[31];
            end
            r.jump   = r.taken;
            r.target = npc + {imm_sx[29:0], 2'b00};
         end
         OP_ADDI, OP_ADDI_UNS: begin r.reg_we = 1'b1; r.reg_idx = rt; r.reg_val = addr; end
         OP_SLTI: begin
            r.reg_we  = 1'b1;
            r.reg_idx = rt;
            r.reg_val = {31'd0, $signed(operand_a) < $signed(imm_sx)};
         end
         OP_SLTI_UNS: begin
            r.reg_we  = 1'b1;
            r.reg_idx = rt;
            r.reg_val = {31'd0, operand_a < imm_sx};
         end
         OP_ORI: begin r.reg_we = 1'b1; r.reg_idx = rt; r.reg_val = operand_a | imm_zx; end
         OP_LUI: begin
            r.reg_we  = 1'b1;
            r.reg_idx = rt;
            r.reg_val = {instruction[15:0], 16'h0000};
         end
         OP_LB, OP_LW, OP_LBU, OP_SB, OP_SW: begin
            r.data_addr = addr;
            r.byte_lane = addr[1:0];
            if (op == OP_SW) begin
               r.store     = 1'b1;
               r.store_val = operand_b;
               r.mem_be    = 4'b1111;
               r.mem_wdata = operand_b;
            end else if (op == OP_SB) begin
               r.store     = 1'b1;
               r.store_val = {24'd0, operand_b[7:0]};
               // big-endian: byte 0 is the top lane
               r.mem_be    = 4'b1000 >> addr[1:0];
               r.mem_wdata = {4{operand_b[7:0]}};
            end else begin
               r.reg_we      = 1'b1;
               r.reg_idx     = rt;
               r.load        = 1'b1;
               r.load_byte   = (op != OP_LW);
               r.load_signed = (op == OP_LB);
            end
         end
         default: r.bad = 1'b1;
      endcase

      // writes to register 0 are dropped
      if (!(r.reg_we && r.reg_idx != 5'd0)) begin
         r.reg_we  = 1'b0;
         r.reg_idx = 5'd0;
         r.reg_val = 32'd0;
         r.load    = 1'b0;
      end

      if (r.bad) begin
         r            = '0;
         r.next_fetch = pc;
         r.bad        = 1'b1;
      end
      result = r;
   end

endmodule

// File: sv/mips_subset_execute_unit.sv
// An accepted instruction is held in the execute register; when it moves on, its
// result is registered into the result stage and presented there.
// Throughput: one instruction per cycle unless req_stall is raised; operands are forwarded from the result
// stage (including load data), so dependent instructions issue back to back.
// Reset: pc 0, no pending redirect, registers read as zero; the data memory is
// then cleared one word per cycle over all 1024 words, during which no item is accepted.
module mips_subset_execute_unit
   import msx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instruction,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_fetch_address,
   output logic        rsp_reg_write_enable,
   output logic [4:0]  rsp_reg_write_index,
   output logic [31:0] rsp_reg_write_value,
   output logic        rsp_store_enable,
   output logic [31:0] rsp_data_address,
   output logic [31:0] rsp_store_value,
   output logic        rsp_branch_taken,
   output logic        rsp_bad_instruction,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   logic                 req_accept;
   logic                 rsp_accept;
   logic                 x_move;

   logic                 x_valid_ff;
   logic [31:0]          x_ins_ff;
   logic                 m_valid_ff;
   exec_result_type      m_res_ff;
   logic [31:0]          m_rdata_ff;

   logic [31:0]          pc_ff;
   logic                 redirect_pending_ff;
   logic [31:0]          redirect_target_ff;

   logic                 clear_busy_ff;
   logic [DMEM_AW-1:0]   clear_idx_ff;
   logic [DMEM_AW-1:0]   clear_idx_in;

   logic [31:0]          dmem_ff [DATA_WORDS];
   logic                 dmem_we;
   logic [DMEM_AW-1:0]   dmem_addr;
   logic [3:0]           dmem_be;
   logic [31:0]          dmem_wdata;

   logic [31:0]          rf_a;
   logic [31:0]          rf_b;
   rf_write_type         rf_wr;
   logic [31:0]          op_a;
   logic [31:0]          op_b;
   exec_result_type      ex_res;

   logic [7:0]           ld_byte;
   logic [31:0]          ld_val;
   logic [31:0]          m_wval;

   // handshake
   assign x_move     = x_valid_ff && (!m_valid_ff || !rsp_stall);
   assign req_stall  = clear_busy_ff || (x_valid_ff && !x_move);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = m_valid_ff;
   assign rsp_accept = m_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            x_valid_ff <= 1'b1;
         end else if (x_move) begin
            x_valid_ff <= 1'b0;
         end
         if (x_move) begin
            m_valid_ff <= 1'b1;
         end else if (rsp_accept) begin
            m_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_ins_ff <= req_instruction;
      end
      if (x_move) begin
         m_res_ff <= ex_res;
      end
   end

   // register file: read on accept, written when the result is handed over
   assign rf_wr.we   = rsp_accept && m_res_ff.reg_we;
   assign rf_wr.idx  = m_res_ff.reg_idx;
   assign rf_wr.data = m_wval;

   msx_regfile u_regfile (
      .clock        (clock),
      .reset        (reset),
      .read_enable  (req_accept),
      .read_index_a (req_instruction[25:21]),
      .read_index_b (req_instruction[20:16]),
      .write_port   (rf_wr),
      .read_data_a  (rf_a),
      .read_data_b  (rf_b)
   );

   // forward from the item waiting in the result stage
   assign op_a = (m_valid_ff && m_res_ff.reg_we && m_res_ff.reg_idx == x_ins_ff[25:21])
                 ? m_wval : rf_a;
   assign op_b = (m_valid_ff && m_res_ff.reg_we && m_res_ff.reg_idx == x_ins_ff[20:16])
                 ? m_wval : rf_b;

   msx_exec u_exec (
      .instruction      (x_ins_ff),
      .operand_a        (op_a),
      .operand_b        (op_b),
      .pc               (pc_ff),
      .redirect_pending (redirect_pending_ff),
      .redirect_target  (redirect_target_ff),
      .result           (ex_res)
   );

   // fetch state advances when a non-bad instruction leaves execute; a csr write loads the pc instead
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff               <= 32'd0;
         redirect_pending_ff <= 1'b0;
         redirect_target_ff  <= 32'd0;
      end else if (csr_write_enable) begin
         pc_ff               <= csr_write_data;
         redirect_pending_ff <= 1'b0;
      end else if (x_move && !ex_res.bad) begin
         pc_ff               <= ex_res.next_fetch;
         redirect_pending_ff <= ex_res.jump;
         if (ex_res.jump) begin
            redirect_target_ff <= ex_res.target;
         end
      end
   end

   // clearing pass after reset
   assign clear_idx_in = clear_idx_ff + DMEM_AW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
      end else if (clear_busy_ff) begin
         clear_idx_ff <= clear_idx_in;
         if (clear_idx_ff == DMEM_AW'(DATA_WORDS - 1)) begin
            clear_busy_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      if (clear_busy_ff) begin
         dmem_we    = 1'b1;
         dmem_addr  = clear_idx_ff;
         dmem_be    = 4'b1111;
         dmem_wdata = 32'd0;
      end else begin
         dmem_we    = x_move && ex_res.store;
         dmem_addr  = ex_res.data_addr[DMEM_AW+1:2];
         dmem_be    = ex_res.mem_be;
         dmem_wdata = ex_res.mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (dmem_we) begin
         for (int k = 0; k < 4; k++) begin
            if (dmem_be[k]) begin
               dmem_ff[dmem_addr][8*k +: 8] <= dmem_wdata[8*k +: 8];
            end
         end
      end
      if (x_move) begin
         m_rdata_ff <= dmem_ff[ex_res.data_addr[DMEM_AW+1:2]];
      end
   end

   // load data alignment in the result stage
   always_comb begin
      unique case (m_res_ff.byte_lane)
         2'd0: ld_byte = m_rdata_ff[31:24];
         2'd1: ld_byte = m_rdata_ff[23:16];
         2'd2: ld_byte = m_rdata_ff[15:8];
         2'd3: ld_byte = m_rdata_ff[7:0];
         default: ld_byte = m_rdata_ff[7:0];
      endcase
      if (!m_res_ff.load_byte) begin
         ld_val = m_rdata_ff;
      end else if (m_res_ff.load_signed) begin
         ld_val = {{24{ld_byte[7]}}, ld_byte};
      end else begin
         ld_val = {24'd0, ld_byte};
      end
   end

   assign m_wval = m_res_ff.load ? ld_val : m_res_ff.reg_val;

   assign rsp_next_fetch_address = m_res_ff.next_fetch;
   assign rsp_reg_write_enable   = m_res_ff.reg_we;
   assign rsp_reg_write_index    = m_res_ff.reg_idx;
   assign rsp_reg_write_value    = m_wval;
   assign rsp_store_enable       = m_res_ff.store;
   assign rsp_data_address       = m_res_ff.data_addr;
   assign rsp_store_value        = m_res_ff.store_val;
   assign rsp_branch_taken       = m_res_ff.taken;
   assign rsp_bad_instruction    = m_res_ff.bad;

   a_bad_no_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_instruction |-> !rsp_reg_write_enable && !rsp_store_enable
         && !rsp_branch_taken)
      else $error("bad instruction item carries side effects");

   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_write_enable |-> rsp_reg_write_index != 5'd0)
      else $error("write to register 0 reported");

   a_store_not_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_store_enable && rsp_reg_write_enable))
      else $error("item both stores and writes a register");

   a_bad_keeps_pc: assert property (@(posedge clock) disable iff (reset)
      x_move && ex_res.bad && !csr_write_enable |=> $stable(pc_ff)
         && $stable(redirect_pending_ff))
      else $error("bad instruction changed fetch state");

   a_jump_sets_redirect: assert property (@(posedge clock) disable iff (reset)
      x_move && ex_res.jump && !csr_write_enable |=> redirect_pending_ff)
      else $error("jump did not leave a pending redirect");

endmodule
